@@ rtl/fcbf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbf_pkg: shared types and constants for the byte FIFO core
// Widths, operation codes, controller state and command bundle.
// ----------------------------------------------------------------------------
package fcbf_pkg;

    // Ring depth; must be a power of two so pointer wrap is a plain truncation.
    localparam int MAX_CAPACITY = 1024;
    localparam int PTR_W        = $clog2(MAX_CAPACITY);
    localparam int CNT_W        = 11;
    localparam int CAP_RESET    = 1024;
    localparam int MODE_W       = 3;
    localparam int BYTE_W       = 8;
    localparam int TOTAL_W      = 32;

    localparam int S_TDATA_W = 24;  // data_byte, amount, zero pad
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE   = 3'd0,
        MODE_READ    = 3'd1,
        MODE_PEEK    = 3'd2,
        MODE_DISCARD = 3'd3,
        MODE_CLOSE   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic load;    // latch input transfer, launch ring read
        logic commit;  // apply state update, load result register
    } cmd_t;

endpackage

@@ rtl/fcbf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbf_ctrl: sequencing controller
// Two-state machine: take a transfer, then commit it once the result
// register is free. Owns the result-valid flag.
// ----------------------------------------------------------------------------
module fcbf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          m_tready,
    output logic          m_tvalid,
    output fcbf_pkg::cmd_t cmd
);
    import fcbf_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !m_valid_reg || m_tready;
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == ST_EXEC) && out_free;
    assign m_tvalid   = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (cmd.commit) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit)    m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/fcbf_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbf_dp: FIFO datapath
// Ring memory, head pointer, fill and transfer counters, capacity
// register and the result register.
// ----------------------------------------------------------------------------
module fcbf_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fcbf_pkg::cmd_t                      cmd,
    input  logic [fcbf_pkg::MODE_W-1:0]         in_mode,
    input  logic [fcbf_pkg::BYTE_W-1:0]         in_byte,
    input  logic [fcbf_pkg::CNT_W-1:0]          in_amount,
    input  logic                                cfg_wr_en,
    input  logic [fcbf_pkg::CNT_W-1:0]          cfg_wr_data,
    output logic                                out_accepted,
    output logic [fcbf_pkg::BYTE_W-1:0]         out_byte,
    output logic [fcbf_pkg::CNT_W-1:0]          out_occupancy,
    output logic [fcbf_pkg::CNT_W-1:0]          out_room_left,
    output logic                                out_closed,
    output logic                                out_eos,
    output logic [fcbf_pkg::TOTAL_W-1:0]        out_written,
    output logic [fcbf_pkg::TOTAL_W-1:0]        out_read
);
    import fcbf_pkg::*;

    logic [BYTE_W-1:0] ring_mem [MAX_CAPACITY];
    logic [BYTE_W-1:0] rd_data_reg;

    // architectural state
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [TOTAL_W-1:0] wr_cnt_reg, wr_cnt_next;
    logic [TOTAL_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic               closed_reg, closed_next;
    logic [CNT_W-1:0]   cap_reg;

    // latched transfer
    logic [MODE_W-1:0]  mode_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic [CNT_W-1:0]   amt_reg;

    // result register
    logic               acc_reg;
    logic [BYTE_W-1:0]  obyte_reg;
    logic [CNT_W-1:0]   occ_reg, room_reg;
    logic               oclosed_reg, eos_reg;
    logic [TOTAL_W-1:0] owr_reg, ord_reg;

    logic [PTR_W-1:0]   rd_offset, rd_addr, wr_addr;
    logic [CNT_W-1:0]   cap_eff, disc_n, room_next;
    logic               acc_next, wr_en;
    logic [BYTE_W-1:0]  obyte_next;

    // read launched with the incoming transfer; only peek uses an offset
    assign rd_offset = (in_mode == MODE_PEEK) ? in_amount[PTR_W-1:0] : '0;
    assign rd_addr   = head_reg + rd_offset;
    assign wr_addr   = head_reg + fill_reg[PTR_W-1:0];

    assign cap_eff = (cap_reg > CNT_W'(MAX_CAPACITY)) ? CNT_W'(MAX_CAPACITY) : cap_reg;
    assign disc_n  = (amt_reg < fill_reg) ? amt_reg : fill_reg;

    always_comb begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        wr_cnt_next = wr_cnt_reg;
        rd_cnt_next = rd_cnt_reg;
        closed_next = closed_reg;
        acc_next    = 1'b0;
        obyte_next  = '0;
        wr_en       = 1'b0;
        case (mode_reg)
            MODE_WRITE: begin
                if (fill_reg < cap_eff) begin
                    wr_en       = 1'b1;
                    fill_next   = fill_reg + 1'b1;
                    wr_cnt_next = wr_cnt_reg + 1'b1;
                    acc_next    = 1'b1;
                end
            end
            MODE_READ: begin
                if (fill_reg != '0) begin
                    obyte_next  = rd_data_reg;
                    head_next   = head_reg + 1'b1;
                    fill_next   = fill_reg - 1'b1;
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    acc_next    = 1'b1;
                end
            end
            MODE_PEEK: begin
                if (amt_reg < fill_reg) begin
                    obyte_next = rd_data_reg;
                    acc_next   = 1'b1;
                end
            end
            MODE_DISCARD: begin
                if (disc_n != '0) begin
                    head_next   = head_reg + disc_n[PTR_W-1:0];
                    fill_next   = fill_reg - disc_n;
                    rd_cnt_next = rd_cnt_reg + TOTAL_W'(disc_n);
                    acc_next    = 1'b1;
                end
            end
            MODE_CLOSE: closed_next = 1'b1;
            default: ;
        endcase
    end

    assign room_next = (cap_eff > fill_next) ? (cap_eff - fill_next) : '0;

    // ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) ring_mem[wr_addr] <= byte_reg;
        if (cmd.load)            rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            fill_reg   <= '0;
            wr_cnt_reg <= '0;
            rd_cnt_reg <= '0;
            closed_reg <= 1'b0;
            cap_reg    <= CNT_W'(CAP_RESET);
        end else begin
            if (cfg_wr_en) cap_reg <= cfg_wr_data;
            if (cmd.commit) begin
                head_reg   <= head_next;
                fill_reg   <= fill_next;
                wr_cnt_reg <= wr_cnt_next;
                rd_cnt_reg <= rd_cnt_next;
                closed_reg <= closed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            byte_reg <= in_byte;
            amt_reg  <= in_amount;
        end
        if (cmd.commit) begin
            acc_reg     <= acc_next;
            obyte_reg   <= obyte_next;
            occ_reg     <= fill_next;
            room_reg    <= room_next;
            oclosed_reg <= closed_next;
            eos_reg     <= closed_next && (fill_next == '0);
            owr_reg     <= wr_cnt_next;
            ord_reg     <= rd_cnt_next;
        end
    end

    assign out_accepted  = acc_reg;
    assign out_byte      = obyte_reg;
    assign out_occupancy = occ_reg;
    assign out_room_left = room_reg;
    assign out_closed    = oclosed_reg;
    assign out_eos       = eos_reg;
    assign out_written   = owr_reg;
    assign out_read      = ord_reg;

endmodule

@@ rtl/flow_controlled_byte_fifo_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_controlled_byte_fifo_core: byte FIFO with flow control
// Ring-buffer byte FIFO driven by an operation stream (write, read, peek,
// discard, end of input); one status result per operation.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready | tuser: mode; tdata: data_byte, amount
//  m_      | out | m_tvalid/m_tready | tuser: accepted; tdata: status fields
//  cfg_    | in  | cfg_wr_en         | capacity (11 bits)
//
//  An operation has two steps: the transfer cycle launches the ring read,
//  then the commit updates state from the registered read data once the
//  result register is free. No new transfer is taken until that commit.
//  Reset (aresetn low, synchronous) empties the FIFO, clears both counters
//  and the end-of-input flag, and restores capacity to 1024. Ring contents
//  are not cleared. A stalled result holds the commit stage; a new transfer
//  is still taken while the previous result waits on m_tready.
// ----------------------------------------------------------------------------
module flow_controlled_byte_fifo_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fcbf_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] data_byte, [18:8] amount
    input  logic [fcbf_pkg::S_TUSER_W-1:0]     s_tuser,  // [2:0] mode
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] out_byte, [18:8] occupancy, [29:19] room_left, [30] input_closed,
    // [31] end_of_stream, [63:32] total_written, [95:64] total_read
    output logic [fcbf_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [fcbf_pkg::M_TUSER_W-1:0]     m_tuser,  // [0] accepted
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [fcbf_pkg::CNT_W-1:0]         cfg_wr_data
);
    import fcbf_pkg::*;

    cmd_t               cmd;
    logic               r_acc, r_closed, r_eos;
    logic [BYTE_W-1:0]  r_byte;
    logic [CNT_W-1:0]   r_occ, r_room;
    logic [TOTAL_W-1:0] r_wr, r_rd;

    fcbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    fcbf_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_mode       (s_tuser[MODE_W-1:0]),
        .in_byte       (s_tdata[7:0]),
        .in_amount     (s_tdata[18:8]),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_accepted  (r_acc),
        .out_byte      (r_byte),
        .out_occupancy (r_occ),
        .out_room_left (r_room),
        .out_closed    (r_closed),
        .out_eos       (r_eos),
        .out_written   (r_wr),
        .out_read      (r_rd)
    );

    assign m_tdata = {r_rd, r_wr, r_eos, r_closed, r_room, r_occ, r_byte};
    assign m_tuser = r_acc;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    // one operation in flight: a transfer always blocks the next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer taken while one is in flight");

    // reported occupancy never exceeds the ring depth
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r_occ <= CNT_W'(MAX_CAPACITY)))
        else $error("occupancy above ring depth");

    // end of stream only when closed and drained
    a_eos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && r_eos) |-> (r_closed && (r_occ == '0)))
        else $error("end_of_stream without closed empty FIFO");

    // a commit always produces a valid result next cycle
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("commit without result");

endmodule
